>>> design/rhht_pkg.sv
// package for the robin hood hash table
// holds shared constants, status codes and controller/datapath command types
package rhht_pkg;

  localparam int unsigned TableSlotsDef = 64;
  localparam int unsigned ValueBitsDef  = 32;
  localparam int unsigned HashW         = 64;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned ReadValueW    = 32;
  localparam int unsigned WriteValueW   = 32;
  localparam int unsigned DistOutW      = 6;
  localparam int unsigned CountOutW     = 7;
  localparam int unsigned FillW         = 7;
  localparam logic [FillW-1:0] FillLimitReset = 7'd58;

  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdLookup = 2'd1;
  localparam logic [CmdW-1:0] CmdDelete = 2'd2;

  localparam logic [StatusW-1:0] StInserted = 3'd0;
  localparam logic [StatusW-1:0] StUpdated  = 3'd1;
  localparam logic [StatusW-1:0] StFound    = 3'd2;
  localparam logic [StatusW-1:0] StNotFound = 3'd3;
  localparam logic [StatusW-1:0] StDeleted  = 3'd4;
  localparam logic [StatusW-1:0] StFull     = 3'd5;

  typedef enum logic [2:0] {
    OpNone,
    OpStart,
    OpStep,
    OpWriteValue,
    OpPlace,
    OpShift,
    OpClear,
    OpMark
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic match;
    logic poorer;
    logic shift_end;
    logic last_probe;
  } dp_status_t;

endpackage

>>> design/rhht_if.sv
// valid/ready channel interface with a parameterised payload type
// depends on nothing
interface rhht_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/robin_hood_hash_table.sv
// Robin Hood hash table, 64-bit hashes, open addressing with backward-shift delete.
// A request probes one slot per cycle from its home slot; an insert then carries each
// displaced entry on through the following slots until one is empty, and a delete
// shifts the entries after it back by one slot until an empty slot or an entry at its
// home slot; one request is in flight at a time and the response register holds until
// taken. TableSlots must be a power of two, the home slot being the low hash bits.
// depends on rhht_pkg, rhht_if, rhht_ctrl and rhht_datapath
module robin_hood_hash_table import rhht_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef,
  parameter int unsigned ValueBits  = ValueBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  rhht_if.sink   req,
  rhht_if.source rsp,
  rhht_if.sink   cfg
);

  localparam int unsigned DistW = $clog2(TableSlots) + 1;

  logic [FillW-1:0]      fill_limit_q;
  dp_cmd_t               dp_cmd;
  dp_status_t            dp_status;
  logic [ValueBits-1:0]  slot_value;
  logic [DistW-1:0]      slot_dist;
  logic [DistW-1:0]      probe_dist;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= FillLimitReset;
    end else if (cfg.valid) begin
      fill_limit_q <= cfg.data.fill_limit;
    end
  end

  rhht_ctrl #(.TableSlots(TableSlots), .ValueBits(ValueBits)) u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i  (req.valid),
    .req_ready_o  (req.ready),
    .req_cmd_i    (req.data.cmd),
    .rsp_ready_i  (rsp.ready),
    .rsp_valid_o  (rsp.valid),
    .rsp_status_o (rsp.data.status),
    .rsp_value_o  (rsp.data.read_value),
    .rsp_dist_o   (rsp.data.probe_distance),
    .rsp_count_o  (rsp.data.entry_count),
    .fill_limit_i (fill_limit_q),
    .dp_cmd_o     (dp_cmd),
    .dp_status_i  (dp_status),
    .slot_value_i (slot_value),
    .slot_dist_i  (slot_dist),
    .probe_dist_i (probe_dist)
  );

  rhht_datapath #(.TableSlots(TableSlots), .ValueBits(ValueBits)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (dp_cmd),
    .hash_i       (req.data.key_hash),
    .value_i      (ValueBits'(req.data.write_value)),
    .status_o     (dp_status),
    .slot_value_o (slot_value),
    .slot_dist_o  (slot_dist),
    .probe_dist_o (probe_dist)
  );

endmodule

>>> design/rhht_datapath.sv
// datapath: slot memories, valid bits, probe pointer and carried entry
// depends on rhht_pkg
module rhht_datapath import rhht_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef,
  parameter int unsigned ValueBits  = ValueBitsDef,
  localparam int unsigned IdxW      = $clog2(TableSlots),
  localparam int unsigned DistW     = $clog2(TableSlots) + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [HashW-1:0]     hash_i,
  input  logic [ValueBits-1:0] value_i,
  output dp_status_t           status_o,
  output logic [ValueBits-1:0] slot_value_o,
  output logic [DistW-1:0]     slot_dist_o,
  output logic [DistW-1:0]     probe_dist_o
);

  logic [TableSlots-1:0] valid_q;
  logic [HashW-1:0]      hash_mem [TableSlots];
  logic [DistW-1:0]      dist_mem [TableSlots];
  logic [ValueBits-1:0]  value_mem [TableSlots];

  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      idx_d;
  logic [IdxW-1:0]      hole_q;
  logic [DistW-1:0]     d_q;
  logic [HashW-1:0]     ch_q;
  logic [ValueBits-1:0] cv_q;
  logic [DistW-1:0]     cd_q;
  logic [DistW-1:0]     probes_q;
  logic [HashW-1:0]     rd_hash_q;
  logic [DistW-1:0]     rd_dist_q;
  logic [ValueBits-1:0] rd_value_q;

  logic [IdxW-1:0] nxt;
  logic            cur_valid;
  logic [IdxW-1:0] home;

  assign home      = hash_i[IdxW-1:0];
  assign nxt       = (idx_q == IdxW'(TableSlots - 1)) ? '0 : idx_q + 1'b1;
  assign cur_valid = valid_q[idx_q];

  assign status_o.empty      = !cur_valid;
  assign status_o.match      = rd_hash_q == ch_q;
  assign status_o.poorer     = rd_dist_q < d_q;
  assign status_o.shift_end  = !cur_valid || rd_dist_q == '0 ||
                               probes_q == DistW'(TableSlots);
  assign status_o.last_probe = probes_q == DistW'(TableSlots - 1);
  assign slot_value_o        = rd_value_q;
  assign slot_dist_o         = rd_dist_q;
  assign probe_dist_o        = d_q;

  // probe pointer for the next cycle, also the read address
  always_comb begin
    idx_d = idx_q;
    case (cmd_i.op)
      OpStart: begin
        idx_d = home;
      end
      OpStep, OpMark, OpShift: begin
        idx_d = nxt;
      end
      OpPlace: begin
        if (cur_valid) idx_d = nxt;
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  // registered read of the slot under the probe pointer
  always_ff @(posedge clk_i) begin
    rd_hash_q  <= hash_mem[idx_d];
    rd_dist_q  <= dist_mem[idx_d];
    rd_value_q <= value_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      case (cmd_i.op)
        OpPlace: begin
          valid_q[idx_q] <= 1'b1;
        end
        OpClear: begin
          valid_q[hole_q] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    case (cmd_i.op)
      OpStart: begin
        d_q      <= '0;
        probes_q <= '0;
        ch_q     <= hash_i;
        cv_q     <= value_i;
        cd_q     <= '0;
      end
      OpStep: begin
        d_q      <= d_q + 1'b1;
        probes_q <= probes_q + 1'b1;
        cd_q     <= d_q + 1'b1;
      end
      OpWriteValue: begin
        value_mem[idx_q] <= cv_q;
      end
      OpMark: begin
        hole_q   <= idx_q;
        probes_q <= '0;
      end
      OpPlace: begin
        if (!cur_valid) begin
          hash_mem[idx_q]  <= ch_q;
          value_mem[idx_q] <= cv_q;
          dist_mem[idx_q]  <= cd_q;
        end else begin
          if (rd_dist_q < cd_q) begin
            hash_mem[idx_q]  <= ch_q;
            value_mem[idx_q] <= cv_q;
            dist_mem[idx_q]  <= cd_q;
            ch_q <= rd_hash_q;
            cv_q <= rd_value_q;
            cd_q <= rd_dist_q + 1'b1;
          end else begin
            cd_q <= cd_q + 1'b1;
          end
        end
      end
      OpShift: begin
        hash_mem[hole_q]  <= rd_hash_q;
        value_mem[hole_q] <= rd_value_q;
        dist_mem[hole_q]  <= rd_dist_q - 1'b1;
        hole_q   <= idx_q;
        probes_q <= probes_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/rhht_ctrl.sv
// controller: sequences search, update, placement and backward shift
// depends on rhht_pkg
module rhht_ctrl import rhht_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef,
  parameter int unsigned ValueBits  = ValueBitsDef,
  localparam int unsigned DistW     = $clog2(TableSlots) + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [CmdW-1:0]       req_cmd_i,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic [StatusW-1:0]    rsp_status_o,
  output logic [ReadValueW-1:0] rsp_value_o,
  output logic [DistOutW-1:0]   rsp_dist_o,
  output logic [CountOutW-1:0]  rsp_count_o,
  input  logic [FillW-1:0]      fill_limit_i,
  output dp_cmd_t               dp_cmd_o,
  input  dp_status_t            dp_status_i,
  input  logic [ValueBits-1:0]  slot_value_i,
  input  logic [DistW-1:0]      slot_dist_i,
  input  logic [DistW-1:0]      probe_dist_i
);

  typedef enum logic [2:0] {
    SIdle,
    SSearch,
    SPlace,
    SShift,
    SResp
  } state_e;

  localparam int unsigned CntW = $clog2(TableSlots + 1);

  state_e               state_q;
  logic [CmdW-1:0]      cmd_q;
  logic [CntW-1:0]      count_q;
  logic [StatusW-1:0]   status_q;
  logic [ReadValueW-1:0] value_q;
  logic [DistOutW-1:0]  dist_q;

  logic full;
  assign full = (CntW'(count_q) >= CntW'(fill_limit_i) && (CntW >= FillW ||
                 fill_limit_i <= FillW'(count_q))) ||
                count_q >= CntW'(TableSlots);

  assign req_ready_o  = state_q == SIdle;
  assign rsp_valid_o  = state_q == SResp;
  assign rsp_status_o = status_q;
  assign rsp_value_o  = value_q;
  assign rsp_dist_o   = dist_q;
  assign rsp_count_o  = CountOutW'(count_q);

  always_comb begin
    dp_cmd_o.op = OpNone;
    case (state_q)
      SIdle: begin
        if (req_valid_i) dp_cmd_o.op = OpStart;
      end
      SSearch: begin
        if (dp_status_i.empty || dp_status_i.poorer) begin
          dp_cmd_o.op = (cmd_q == CmdInsert && !full) ? OpPlace : OpNone;
        end else if (dp_status_i.match) begin
          case (cmd_q)
            CmdInsert: dp_cmd_o.op = OpWriteValue;
            CmdDelete: dp_cmd_o.op = OpMark;
            default:   dp_cmd_o.op = OpNone;
          endcase
        end else if (!dp_status_i.last_probe) begin
          dp_cmd_o.op = OpStep;
        end
      end
      SPlace: dp_cmd_o.op = OpPlace;
      SShift: dp_cmd_o.op = dp_status_i.shift_end ? OpClear : OpShift;
      default: dp_cmd_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      cmd_q    <= CmdInsert;
      count_q  <= '0;
      status_q <= StNotFound;
      value_q  <= '0;
      dist_q   <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (req_valid_i) begin
            cmd_q    <= req_cmd_i;
            status_q <= StNotFound;
            value_q  <= '0;
            dist_q   <= '0;
            state_q  <= (req_cmd_i == CmdInsert || req_cmd_i == CmdLookup ||
                         req_cmd_i == CmdDelete) ? SSearch : SResp;
          end
        end
        SSearch: begin
          if (dp_status_i.empty || dp_status_i.poorer) begin
            if (cmd_q == CmdInsert) begin
              if (full) begin
                status_q <= StFull;
                state_q  <= SResp;
              end else begin
                status_q <= StInserted;
                dist_q   <= DistOutW'(probe_dist_i);
                count_q  <= count_q + 1'b1;
                state_q  <= dp_status_i.empty ? SResp : SPlace;
              end
            end else begin
              state_q <= SResp;
            end
          end else if (dp_status_i.match) begin
            dist_q <= DistOutW'(slot_dist_i);
            case (cmd_q)
              CmdInsert: begin
                status_q <= StUpdated;
                state_q  <= SResp;
              end
              CmdLookup: begin
                status_q <= StFound;
                value_q  <= ReadValueW'(slot_value_i);
                state_q  <= SResp;
              end
              default: begin
                status_q <= StDeleted;
                count_q  <= count_q - 1'b1;
                state_q  <= SShift;
              end
            endcase
          end else if (dp_status_i.last_probe) begin
            if (cmd_q == CmdInsert) status_q <= StFull;
            state_q <= SResp;
          end
        end
        SPlace: begin
          if (dp_status_i.empty) state_q <= SResp;
        end
        SShift: begin
          if (dp_status_i.shift_end) state_q <= SResp;
        end
        SResp: begin
          if (rsp_ready_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
